// ===== src/hrhp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hrhp_pkg;

  localparam logic [31:0] SAT32           = 32'hFFFF_FFFF;
  localparam logic [31:0] DEFAULT_AGE_RST = 32'd3600;

  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_UPPERC = 8'h43;
  localparam logic [7:0] CH_LOWERM = 8'h6D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // Line-level parse modes.
  typedef enum logic [3:0] {
    MODE_LINE_START = 4'd0,
    MODE_PFX_BOTH   = 4'd1,
    MODE_PFX_LEN    = 4'd2,
    MODE_PFX_CACHE  = 4'd3,
    MODE_OTHER      = 4'd4,
    MODE_LEN_DIGITS = 4'd5,
    MODE_LEN_REST   = 4'd6,
    MODE_CC_SCAN    = 4'd7,
    MODE_CC_DIGITS  = 4'd8,
    MODE_SKIP_ONE   = 4'd9,
    MODE_END_NEXT   = 4'd10,
    MODE_DONE       = 4'd11
  } mode_t;

  typedef struct packed {
    logic [31:0] header_length;
    logic [31:0] content_length;
    logic [31:0] max_age;
    logic        age_from_header;
  } result_t;

  // Characters of "Content-Length: ".
  function automatic logic [7:0] key_len_char(input logic [3:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0:    ch = 8'h43;
      4'd1:    ch = 8'h6F;
      4'd2:    ch = 8'h6E;
      4'd3:    ch = 8'h74;
      4'd4:    ch = 8'h65;
      4'd5:    ch = 8'h6E;
      4'd6:    ch = 8'h74;
      4'd7:    ch = 8'h2D;
      4'd8:    ch = 8'h4C;
      4'd9:    ch = 8'h65;
      4'd10:   ch = 8'h6E;
      4'd11:   ch = 8'h67;
      4'd12:   ch = 8'h74;
      4'd13:   ch = 8'h68;
      4'd14:   ch = 8'h3A;
      default: ch = 8'h20;
    endcase
    return ch;
  endfunction

  // Characters of "Cache-Control: "; index 15 never matches.
  function automatic logic [7:0] key_cache_char(input logic [3:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0:    ch = 8'h43;
      4'd1:    ch = 8'h61;
      4'd2:    ch = 8'h63;
      4'd3:    ch = 8'h68;
      4'd4:    ch = 8'h65;
      4'd5:    ch = 8'h2D;
      4'd6:    ch = 8'h43;
      4'd7:    ch = 8'h6F;
      4'd8:    ch = 8'h6E;
      4'd9:    ch = 8'h74;
      4'd10:   ch = 8'h72;
      4'd11:   ch = 8'h6F;
      4'd12:   ch = 8'h6C;
      4'd13:   ch = 8'h3A;
      4'd14:   ch = 8'h20;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Characters of "max-age=".
  function automatic logic [7:0] key_age_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h6D;
      3'd1:    ch = 8'h61;
      3'd2:    ch = 8'h78;
      3'd3:    ch = 8'h2D;
      3'd4:    ch = 8'h61;
      3'd5:    ch = 8'h67;
      3'd6:    ch = 8'h65;
      default: ch = 8'h3D;
    endcase
    return ch;
  endfunction

  // value * 10 + digit, saturating at the full 32-bit range.
  function automatic logic [31:0] add_digit(input logic [31:0] v, input logic [3:0] d);
    logic [35:0] t;
    t = ({4'd0, v} << 3) + ({4'd0, v} << 1) + {32'd0, d};
    return (|t[35:32]) ? SAT32 : t[31:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/hrhp_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hrhp_parser (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            accept,
  input  wire logic [7:0]      data_byte,
  input  wire logic            start_of_message,
  input  wire logic [31:0]     default_age,
  output logic                 res_push,
  output hrhp_pkg::result_t    res_data
);
  import hrhp_pkg::*;

  mode_t       mode_r,     mode_nxt;
  logic [4:0]  match_r,    match_nxt;
  logic [31:0] len_r,      len_nxt;
  logic [31:0] age_r,      age_nxt;
  logic        seen_r,     seen_nxt;
  logic [31:0] count_r,    count_nxt;
  logic        fin_r,      fin_nxt;

  mode_t       eff_mode;
  logic [4:0]  eff_match;
  logic [31:0] eff_len;
  logic [31:0] eff_age;
  logic        eff_seen;
  logic [31:0] eff_count;
  logic        eff_fin;

  logic        is_digit;
  logic [3:0]  pfx_idx;
  logic        do_scan;
  logic [2:0]  scan_idx;
  logic        emit;

  assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
  assign pfx_idx  = eff_match[3:0];

  always_comb begin
    // A start mark clears the parse state before the byte is parsed.
    if (start_of_message) begin
      eff_mode  = MODE_LINE_START;
      eff_match = '0;
      eff_len   = '0;
      eff_age   = '0;
      eff_seen  = 1'b0;
      eff_count = '0;
      eff_fin   = 1'b0;
    end else begin
      eff_mode  = mode_r;
      eff_match = match_r;
      eff_len   = len_r;
      eff_age   = age_r;
      eff_seen  = seen_r;
      eff_count = count_r;
      eff_fin   = fin_r;
    end

    mode_nxt  = eff_mode;
    match_nxt = eff_match;
    len_nxt   = eff_len;
    age_nxt   = eff_age;
    seen_nxt  = eff_seen;
    count_nxt = eff_count;
    fin_nxt   = eff_fin;
    do_scan   = 1'b0;
    scan_idx  = eff_match[2:0];
    emit      = 1'b0;

    if (!eff_fin) begin
      if (eff_count != SAT32) begin
        count_nxt = eff_count + 32'd1;
      end

      case (eff_mode)
        MODE_LINE_START: begin
          if (data_byte == CH_CR) begin
            mode_nxt = MODE_END_NEXT;
          end else if (data_byte == CH_UPPERC) begin
            mode_nxt  = MODE_PFX_BOTH;
            match_nxt = 5'd1;
          end else if (data_byte != CH_LF) begin
            mode_nxt = MODE_OTHER;
          end
        end
        MODE_PFX_BOTH: begin
          if (data_byte == key_len_char(4'd1)) begin
            mode_nxt  = MODE_PFX_LEN;
            match_nxt = 5'd2;
          end else if (data_byte == key_cache_char(4'd1)) begin
            mode_nxt  = MODE_PFX_CACHE;
            match_nxt = 5'd2;
          end else begin
            mode_nxt  = (data_byte == CH_LF) ? MODE_LINE_START : MODE_OTHER;
            match_nxt = '0;
          end
        end
        MODE_PFX_LEN: begin
          if (data_byte == key_len_char(pfx_idx)) begin
            if (pfx_idx == 4'd15) begin
              mode_nxt  = MODE_LEN_DIGITS;
              match_nxt = '0;
              len_nxt   = '0;
            end else begin
              match_nxt = {1'b0, pfx_idx} + 5'd1;
            end
          end else begin
            mode_nxt  = (data_byte == CH_LF) ? MODE_LINE_START : MODE_OTHER;
            match_nxt = '0;
          end
        end
        MODE_PFX_CACHE: begin
          if ((pfx_idx != 4'd15) && (data_byte == key_cache_char(pfx_idx))) begin
            if (pfx_idx == 4'd14) begin
              mode_nxt  = MODE_CC_SCAN;
              match_nxt = '0;
            end else begin
              match_nxt = {1'b0, pfx_idx} + 5'd1;
            end
          end else begin
            mode_nxt  = (data_byte == CH_LF) ? MODE_LINE_START : MODE_OTHER;
            match_nxt = '0;
          end
        end
        MODE_OTHER: begin
          if (data_byte == CH_LF) begin
            mode_nxt = MODE_LINE_START;
          end
        end
        MODE_LEN_DIGITS: begin
          if (is_digit) begin
            len_nxt = add_digit(eff_len, data_byte[3:0]);
          end else begin
            mode_nxt = (data_byte == CH_CR) ? MODE_SKIP_ONE : MODE_LEN_REST;
          end
        end
        MODE_LEN_REST: begin
          if (data_byte == CH_CR) begin
            mode_nxt = MODE_SKIP_ONE;
          end
        end
        MODE_CC_SCAN: begin
          do_scan = 1'b1;
        end
        MODE_CC_DIGITS: begin
          if (is_digit) begin
            age_nxt = add_digit(eff_age, data_byte[3:0]);
          end else begin
            // The digit run ends; this byte restarts the max-age search.
            mode_nxt  = MODE_CC_SCAN;
            match_nxt = '0;
            do_scan   = 1'b1;
            scan_idx  = 3'd0;
          end
        end
        MODE_SKIP_ONE: begin
          mode_nxt  = MODE_LINE_START;
          match_nxt = '0;
        end
        MODE_END_NEXT: begin
          mode_nxt = MODE_DONE;
          fin_nxt  = 1'b1;
          emit     = 1'b1;
        end
        default: begin
          mode_nxt = MODE_DONE;
          fin_nxt  = 1'b1;
        end
      endcase

      if (do_scan) begin
        if (data_byte == CH_CR) begin
          mode_nxt = MODE_SKIP_ONE;
        end else if (data_byte == key_age_char(scan_idx)) begin
          if (scan_idx == 3'd7) begin
            mode_nxt  = MODE_CC_DIGITS;
            age_nxt   = '0;
            seen_nxt  = 1'b1;
            match_nxt = '0;
          end else begin
            match_nxt = {2'b00, scan_idx} + 5'd1;
          end
        end else begin
          match_nxt = (data_byte == CH_LOWERM) ? 5'd1 : 5'd0;
        end
      end
    end
  end

  assign res_push                 = accept && emit;
  assign res_data.header_length   = count_nxt;
  assign res_data.content_length  = eff_len;
  assign res_data.max_age         = eff_seen ? eff_age : default_age;
  assign res_data.age_from_header = eff_seen;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_LINE_START;
      match_r <= '0;
      len_r   <= '0;
      age_r   <= '0;
      seen_r  <= 1'b0;
      count_r <= '0;
      fin_r   <= 1'b0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      match_r <= match_nxt;
      len_r   <= len_nxt;
      age_r   <= age_nxt;
      seen_r  <= seen_nxt;
      count_r <= count_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/hrhp_result_buf.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hrhp_result_buf (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire hrhp_pkg::result_t push_data,
  output logic                 full,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output hrhp_pkg::result_t    out_data
);
  import hrhp_pkg::*;

  // Entry 0 drives the output; entry 1 is the skid slot.
  result_t e0_r, e1_r;
  logic    v0_r, v1_r;
  logic    pop;

  assign pop       = v0_r && !out_stall;
  assign full      = v1_r;
  assign out_valid = v0_r;
  assign out_data  = e0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else if (pop) begin
      if (v1_r) begin
        e0_r <= e1_r;
        if (push) begin
          e1_r <= push_data;
        end else begin
          v1_r <= 1'b0;
        end
      end else if (push) begin
        e0_r <= push_data;
      end else begin
        v0_r <= 1'b0;
      end
    end else if (push) begin
      if (!v0_r) begin
        e0_r <= push_data;
        v0_r <= 1'b1;
      end else begin
        e1_r <= push_data;
        v1_r <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/http_response_header_parser_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  in_data_byte[7:0], in_start_of_message
// out_      output     out_valid/out_stall  out_header_length, out_content_length,
//                                           out_max_age, out_age_from_header
// cfg_      input      cfg_valid/cfg_ready  cfg_data[31:0] (default age)
//
// One byte is taken per cycle while in_stall is low. The parse state updates at
// the edge of the input transaction; a result, if any, enters the result buffer
// at that edge; with the buffer empty, out_valid rises in the following cycle.
// The rate is set by the combinational matcher and decimal accumulator.
// Reset (synchronous, rst_n low) clears the parse state and sets the default
// age to 3600. in_stall rises only when both result slots are occupied, so a
// stalled output does not hold up input until a second result is waiting.

module http_response_header_parser_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_start_of_message,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_header_length,
  output logic [31:0]      out_content_length,
  output logic [31:0]      out_max_age,
  output logic             out_age_from_header,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);
  import hrhp_pkg::*;

  logic        accept;
  logic        buf_full;
  logic        res_push;
  result_t     res_data;
  result_t     out_data;
  logic [31:0] default_age_r;

  // The configuration register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_age_r <= DEFAULT_AGE_RST;
    end else if (cfg_valid) begin
      default_age_r <= cfg_data;
    end
  end

  // An input transaction completes whenever the result buffer has room.
  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  hrhp_parser u_parser (
    .clk              (clk),
    .rst_n            (rst_n),
    .accept           (accept),
    .data_byte        (in_data_byte),
    .start_of_message (in_start_of_message),
    .default_age      (default_age_r),
    .res_push         (res_push),
    .res_data         (res_data)
  );

  hrhp_result_buf u_result_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_data),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_header_length   = out_data.header_length;
  assign out_content_length  = out_data.content_length;
  assign out_max_age         = out_data.max_age;
  assign out_age_from_header = out_data.age_from_header;

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the HTTP response header parser.
// Bytes are offered one transaction at a time. Each accepted byte is run through
// a behavioural copy of the parser held here. That copy queues the result the
// block should give when a header completes. A separate process compares every
// accepted result with the oldest queued one.
module tb_top;
  import hrhp_pkg::*;

  // A result is one register stage behind its input byte. Spare cycles are
  // allowed for that before the default age is changed and at the end.
  localparam int SETTLE_CYCLES = 4;
  // The longest quiet spell in a correct run is a sender gap plus a receiver
  // stall, plus a settle. The limit is far above that.
  localparam int WATCHDOG_LIMIT = 1000;
  // Bytes sent over the whole run, and the share of them left for the final
  // full-rate stretch.
  localparam int TOTAL_ITEMS = 1200;
  localparam int FINAL_ITEMS = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_start_of_message = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_header_length;
  logic [31:0] out_content_length;
  logic [31:0] out_max_age;
  logic        out_age_from_header;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = 32'd0;

  http_response_header_parser_unit uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_data_byte        (in_data_byte),
    .in_start_of_message (in_start_of_message),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_header_length   (out_header_length),
    .out_content_length  (out_content_length),
    .out_max_age         (out_max_age),
    .out_age_from_header (out_age_from_header),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data)
  );

  always #6 clk = ~clk;

  // The three keys that the parser looks for, and a line end.
  string len_key   = "Content-Length: ";
  string cache_key = "Cache-Control: ";
  string age_key   = "max-age=";
  string crlf      = "\015\n";

  // Shadow copy of the parser state and of the default age register.
  mode_t       pm_mode;
  logic [4:0]  pm_pos;
  logic [31:0] pm_len;
  logic [31:0] pm_age;
  logic        pm_age_seen;
  logic [31:0] pm_count;
  logic        pm_done;
  logic [31:0] model_default_age = DEFAULT_AGE_RST;

  result_t expected_headers[$];

  int  failures = 0;
  int  sent_bytes = 0;
  // Start-of-message flag for the next byte sent; it is cleared once that byte goes.
  logic mark_next = 1'b0;
  // Once set, neither side idles any more.
  bit  calm = 1'b0;
  int  stall_left = 0;
  int  idle_cycles = 0;

  // Only the first ten failures are described in full; the rest are just counted.
  task automatic flag_failure(input string msg);
    failures++;
    if (failures <= 10) $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  task automatic clear_parse_model();
    pm_mode = MODE_LINE_START;
    pm_pos = '0;
    pm_len = '0;
    pm_age = '0;
    pm_age_seen = 1'b0;
    pm_count = '0;
    pm_done = 1'b0;
  endtask

  // Decimal accumulation that sticks at the top of the 32-bit range.
  function automatic logic [31:0] scale_add_digit(input logic [31:0] v, input logic [7:0] ch);
    logic [63:0] t;
    t = {32'd0, v} * 64'd10 + {56'd0, ch - CH_ZERO};
    return (t > {32'd0, SAT32}) ? SAT32 : t[31:0];
  endfunction

  // A prefix has stopped matching, so the line is an ordinary one. An LF at the
  // point of mismatch ends it at once.
  task automatic drop_prefix(input logic [7:0] b);
    pm_mode = (b == CH_LF) ? MODE_LINE_START : MODE_OTHER;
    pm_pos = '0;
  endtask

  // Searches a Cache-Control line for the next max-age token. A CR ends the line.
  task automatic scan_age_token(input logic [7:0] b);
    logic [2:0] m;
    m = pm_pos[2:0];
    if (b == CH_CR) begin
      pm_mode = MODE_SKIP_ONE;
    end else if (b == age_key[m]) begin
      if (m == 3'd7) begin
        pm_mode = MODE_CC_DIGITS;
        pm_age = '0;
        pm_age_seen = 1'b1;
        pm_pos = '0;
      end else begin
        pm_pos = {2'b00, m} + 5'd1;
      end
    end else begin
      pm_pos = (b == CH_LOWERM) ? 5'd1 : 5'd0;
    end
  endtask

  // Advances the shadow parser by one accepted byte. When the byte closes a
  // header, the result it should produce is queued.
  task automatic track_header_byte(input logic [7:0] b, input logic som);
    int p;
    result_t r;
    if (som) clear_parse_model();
    if (!pm_done) begin
      if (pm_count != SAT32) pm_count = pm_count + 32'd1;
      case (pm_mode)
        MODE_LINE_START: begin
          if (b == CH_CR) begin
            pm_mode = MODE_END_NEXT;
          end else if (b == CH_UPPERC) begin
            pm_mode = MODE_PFX_BOTH;
            pm_pos = 5'd1;
          end else if (b != CH_LF) begin
            pm_mode = MODE_OTHER;
          end
        end
        MODE_PFX_BOTH: begin
          if (b == len_key[1]) begin
            pm_mode = MODE_PFX_LEN;
            pm_pos = 5'd2;
          end else if (b == cache_key[1]) begin
            pm_mode = MODE_PFX_CACHE;
            pm_pos = 5'd2;
          end else begin
            drop_prefix(b);
          end
        end
        MODE_PFX_LEN: begin
          p = int'(pm_pos[3:0]);
          if (b == len_key[p]) begin
            p++;
            pm_pos = p[4:0];
            if (p >= 16) begin
              pm_mode = MODE_LEN_DIGITS;
              pm_pos = '0;
              pm_len = '0;
            end
          end else begin
            drop_prefix(b);
          end
        end
        MODE_PFX_CACHE: begin
          p = int'(pm_pos[3:0]);
          if (p < 15 && b == cache_key[p]) begin
            p++;
            pm_pos = p[4:0];
            if (p >= 15) begin
              pm_mode = MODE_CC_SCAN;
              pm_pos = '0;
            end
          end else begin
            drop_prefix(b);
          end
        end
        MODE_OTHER: begin
          if (b == CH_LF) pm_mode = MODE_LINE_START;
        end
        MODE_LEN_DIGITS: begin
          if (b >= CH_ZERO && b <= CH_NINE) pm_len = scale_add_digit(pm_len, b);
          else pm_mode = (b == CH_CR) ? MODE_SKIP_ONE : MODE_LEN_REST;
        end
        MODE_LEN_REST: begin
          if (b == CH_CR) pm_mode = MODE_SKIP_ONE;
        end
        MODE_CC_SCAN: begin
          scan_age_token(b);
        end
        MODE_CC_DIGITS: begin
          if (b >= CH_ZERO && b <= CH_NINE) begin
            pm_age = scale_add_digit(pm_age, b);
          end else begin
            pm_mode = MODE_CC_SCAN;
            pm_pos = '0;
            scan_age_token(b);
          end
        end
        MODE_SKIP_ONE: begin
          pm_mode = MODE_LINE_START;
          pm_pos = '0;
        end
        MODE_END_NEXT: begin
          pm_mode = MODE_DONE;
          pm_done = 1'b1;
          r.header_length = pm_count;
          r.content_length = pm_len;
          r.max_age = pm_age_seen ? pm_age : model_default_age;
          r.age_from_header = pm_age_seen;
          expected_headers.push_back(r);
        end
        default: begin
          pm_mode = MODE_DONE;
          pm_done = 1'b1;
        end
      endcase
    end
  endtask

  // Offers one byte and returns at the edge where the transaction completes.
  // The valid is left high, so a following call in the same step simply
  // replaces the payload. Anything else lowers it first.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 9) == 0) gap = $urandom_range(1, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_start_of_message <= mark_next;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_header_byte(b, mark_next);
    sent_bytes++;
    mark_next = 1'b0;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // A CR and the byte that follows it. Mostly that is an LF, but sometimes any
  // byte, because the parser skips or consumes it without looking at it.
  task automatic send_cr_pair();
    send_byte(CH_CR);
    send_byte(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : CH_LF);
  endtask

  // The input is lowered, then everything queued is allowed to arrive. The
  // last pass-through cycles cover bytes that produce no result.
  task automatic settle_parser();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_headers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_default_age(input logic [31:0] v);
    settle_parser();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model_default_age = v;
    cfg_valid <= 1'b0;
  endtask

  // Digit runs from empty up to well past the 32-bit range.
  function automatic string decimal_text();
    case ($urandom_range(0, 5))
      0: return "";
      1: return $sformatf("%0d", $urandom_range(0, 9));
      2: return $sformatf("%0d", $urandom_range(0, 99999));
      3: return $sformatf("%0d", $urandom);
      4: return "4294967295";
      default: return $sformatf("%0d%0d", $urandom_range(1, 99999), $urandom);
    endcase
  endfunction

  // One random response: usually a well-formed header with random content,
  // and now and then a burst of raw noise.
  task automatic send_message();
    string base;
    mark_next = ($urandom_range(0, 9) != 0);
    if ($urandom_range(0, 9) == 0) begin
      // The noise leans towards the characters that steer the parser.
      repeat ($urandom_range(1, 16)) begin
        case ($urandom_range(0, 4))
          0: send_byte(CH_CR);
          1: send_byte(CH_LF);
          2: send_byte(CH_UPPERC);
          default: send_byte(8'($urandom_range(0, 255)));
        endcase
        if ($urandom_range(0, 15) == 0) mark_next = 1'b1;
      end
    end else begin
      if ($urandom_range(0, 1) == 1) send_text({"HTTP/1.1 200 OK", crlf});
      repeat ($urandom_range(0, 3)) begin
        case ($urandom_range(0, 4))
          0: begin
            send_text(len_key);
            case ($urandom_range(0, 5))
              0: send_byte("+");
              1: send_byte(" ");
              default: ;
            endcase
            send_text(decimal_text());
            if ($urandom_range(0, 3) == 0) send_text("; x=1");
            send_cr_pair();
          end
          1: begin
            send_text(cache_key);
            repeat ($urandom_range(0, 3)) begin
              case ($urandom_range(0, 5))
                0, 1: send_text({age_key, decimal_text()});
                2: send_text("no-cache");
                3: send_text({"m", age_key, decimal_text()});
                4: send_text("max-ag");
                default: send_byte(8'($urandom_range(32, 126)));
              endcase
              if ($urandom_range(0, 1) == 1) send_text(", ");
            end
            send_cr_pair();
          end
          2: begin
            // A key that breaks off part-way, sometimes right at an LF.
            base = ($urandom_range(0, 1) == 1) ? len_key : cache_key;
            send_text(base.substr(0, $urandom_range(0, base.len() - 2)));
            case ($urandom_range(0, 3))
              0: send_byte(CH_LF);
              1: send_byte("x");
              2: send_byte(CH_UPPERC);
              default: send_byte(CH_CR);
            endcase
            send_text("\n");
          end
          default: begin
            if ($urandom_range(0, 2) == 0) send_byte(CH_UPPERC);
            repeat ($urandom_range(0, 8)) send_byte(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1) == 1) send_text("\n");
            else send_text(crlf);
          end
        endcase
      end
      send_cr_pair();
      // Body bytes after the header are ignored by the block.
      repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // After reset the first message needs no start mark. The bytes that follow
  // the completed header, 0xFF and 0x00 among them, must be ignored.
  task automatic test_without_start_mark();
    mark_next = 1'b0;
    send_text({"HTTP/1.1 200", crlf, "Content-Length: 42", crlf, crlf});
    send_byte(8'hFF);
    send_byte(8'h00);
  endtask

  // This test covers an LF-only line, the last of several max-age tokens
  // winning, and a saturating length. It also covers a header whose closing
  // CR is followed by a zero byte.
  task automatic test_header_fields();
    mark_next = 1'b1;
    send_text({"X\n", "Cache-Control: public, max-age=120, max-age=7", crlf});
    send_text({"Content-Length: 4294967296", crlf});
    send_byte(CH_CR);
    send_byte(8'h00);
  endtask

  // This test covers a signed length (which reads as zero), an empty age and a
  // saturating age, and a skipped byte after CR. It also covers prefixes that
  // break at an LF and at another character.
  task automatic test_number_edges();
    mark_next = 1'b1;
    send_text({"Content-Length: +5", crlf});
    send_text("Cache-Control: max-age=,mmax-age=99999999999");
    send_byte(CH_CR);
    send_byte("Z");
    send_text({"Content-Le\nContent-Lenx\n", crlf});
  endtask

  // A start mark in the middle of a header throws away what was parsed so far.
  task automatic test_restart_mid_header();
    mark_next = 1'b1;
    send_text("Cache-Control: max-age=5");
    mark_next = 1'b1;
    send_text(crlf);
  endtask

  // This test walks the default age through both extremes, a random value and
  // back to the reset value. Each header shows the register value, except the
  // one that carries its own max-age of zero.
  task automatic test_default_age_settings();
    write_default_age(32'd0);
    mark_next = 1'b1;
    send_text(crlf);
    write_default_age(SAT32);
    mark_next = 1'b1;
    send_text({"Age: 1", crlf, crlf});
    write_default_age($urandom);
    mark_next = 1'b1;
    send_text({"Cache-Control: max-age=0", crlf, crlf});
    mark_next = 1'b1;
    send_text({"Content-Length: 7", crlf, crlf});
    write_default_age(DEFAULT_AGE_RST);
    mark_next = 1'b1;
    send_text(crlf);
  endtask

  // This test sends random responses until all but the final share of the
  // byte budget has been sent. A default age is written every dozen messages.
  task automatic test_random_traffic();
    int msgs;
    msgs = 0;
    while (sent_bytes < TOTAL_ITEMS - FINAL_ITEMS) begin
      send_message();
      msgs++;
      if (msgs % 12 == 0) begin
        case ($urandom_range(0, 3))
          0: write_default_age(32'd0);
          1: write_default_age(SAT32);
          2: write_default_age(DEFAULT_AGE_RST);
          default: write_default_age($urandom);
        endcase
      end
    end
  endtask

  // The last stretch runs at full rate, with neither side idling.
  task automatic test_back_to_back();
    calm = 1'b1;
    while (sent_bytes < TOTAL_ITEMS) send_message();
  endtask

  // The receiver stalls in random bursts, unless reset is active or the run is
  // in its final stretch.
  always @(posedge clk) begin
    if (!rst_n || calm) stall_left = 0;
    else if (stall_left > 0) stall_left = stall_left - 1;
    else if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(1, 19);
    out_stall <= (stall_left > 0);
  end

  // Every completed output transaction is checked against the oldest queued result.
  always @(posedge clk) begin : check_results
    result_t want;
    result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_header_length, out_content_length, out_max_age, out_age_from_header};
      if (expected_headers.size() == 0) begin
        flag_failure($sformatf("result with none expected: header_length %0d",
                               got.header_length));
      end else begin
        want = expected_headers.pop_front();
        if (got !== want) begin
          flag_failure($sformatf(
            "header_length %0d/%0d content_length %0d/%0d max_age %0d/%0d from_header %0b/%0b",
            want.header_length, got.header_length, want.content_length, got.content_length,
            want.max_age, got.max_age, want.age_from_header, got.age_from_header));
        end
      end
    end
  end

  // The run is stopped if no transaction of any kind completes for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles = idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    clear_parse_model();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_without_start_mark();
    test_header_fields();
    test_number_edges();
    test_restart_mid_header();
    test_default_age_settings();
    test_random_traffic();
    test_back_to_back();
    settle_parser();
    if (failures == 0 && expected_headers.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
